>>> hdl/psc_pkg.sv
package psc_pkg;

  localparam int COORD_BITS     = 24;
  localparam int STEP_BITS      = 16;
  localparam int COL_BITS       = 12;
  localparam int ROW_BITS       = 12;
  localparam int SLOT_BITS      = 2;
  localparam int CFG_INDEX_BITS = 2;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int NORM_W  = PROD_W + 1;
  localparam int IDX_W   = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
  localparam int OFFS_W  = IDX_W + STEP_BITS;
  localparam int DELTA_W = ((DIFF_W > OFFS_W) ? DIFF_W : OFFS_W) + 1;
  localparam int LO_W    = (NORM_W + 1) / 2;
  localparam int HI_W    = NORM_W - LO_W;
  localparam int PLO_W   = LO_W + 1 + DELTA_W;
  localparam int PHI_W   = HI_W + DELTA_W;
  localparam int TERM_W  = NORM_W + DELTA_W;
  localparam int SUM_W   = TERM_W + 2;

  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_CLASSIFY = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_X   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_Y   = 2'd3;

  localparam logic signed [1:0] SIDE_BELOW = -2'sd1;
  localparam logic signed [1:0] SIDE_ON    = 2'sd0;
  localparam logic signed [1:0] SIDE_ABOVE = 2'sd1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [STEP_BITS-1:0]  step_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [NORM_W-1:0]     norm_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } psc_point_t;

  typedef struct packed {
    norm_t a;
    norm_t b;
    norm_t c;
  } psc_normal_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic commit;
    logic s4;
    logic s5;
    logic s6;
    logic out;
  } psc_en_t;

endpackage

>>> hdl/plane_side_pixel_classifier.sv
// A sample item's result passes through stages s1 to s6 and is registered at the outputs.
// Throughput: one item per cycle unless out_ready stalls; load items give no result
// and leave after the third stage, where they write the recomputed normal.
// Reset (rst, synchronous, active high) empties the pipeline, clears the loaded-point
// flags and the normal, and returns the registers to their defaults; points are kept.
module plane_side_pixel_classifier (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    action,
  input  logic [psc_pkg::SLOT_BITS-1:0]           point_slot,
  input  logic signed [psc_pkg::COORD_BITS-1:0]   point_x,
  input  logic signed [psc_pkg::COORD_BITS-1:0]   point_y,
  input  logic signed [psc_pkg::COORD_BITS-1:0]   elevation,
  input  logic [psc_pkg::COL_BITS-1:0]            column,
  input  logic [psc_pkg::ROW_BITS-1:0]            row,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [1:0]                       side,
  output logic                                    plane_valid,
  input  logic                                    cfg_write,
  input  logic [psc_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [psc_pkg::COORD_BITS-1:0]          cfg_data
);
  import psc_pkg::*;

  coord_t origin_x, origin_y;
  step_t step_x, step_y;
  psc_en_t en;
  psc_point_t anchor;
  psc_normal_t normal;
  logic complete;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      step_x   <= STEP_BITS'(1);
      step_y   <= STEP_BITS'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ORIGIN_X: origin_x <= cfg_data;
        CFG_ORIGIN_Y: origin_y <= cfg_data;
        CFG_STEP_X:   step_x   <= cfg_data[STEP_BITS-1:0];
        CFG_STEP_Y:   step_y   <= cfg_data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .en        (en)
  );

  psc_plane u_plane (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .action     (action),
    .point_slot (point_slot),
    .point_x    (point_x),
    .point_y    (point_y),
    .elevation  (elevation),
    .anchor     (anchor),
    .complete   (complete),
    .normal     (normal)
  );

  psc_sample u_sample (
    .clk         (clk),
    .en          (en),
    .column      (column),
    .row         (row),
    .elevation   (elevation),
    .anchor      (anchor),
    .complete    (complete),
    .normal      (normal),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .step_x      (step_x),
    .step_y      (step_y),
    .side        (side),
    .plane_valid (plane_valid)
  );

endmodule

>>> hdl/psc_ctrl.sv
module psc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             action,
  input  logic             out_ready,
  output logic             in_ready,
  output logic             out_valid,
  output psc_pkg::psc_en_t en
);
  import psc_pkg::*;

  logic v1, v2, v3, v4, v5, v6, ov;
  logic k1, k2, k3;
  logic r_out, r6, r5, r4, r3, r2, r1, leave3;

  assign r_out  = !ov || out_ready;
  assign r6     = !v6 || r_out;
  assign r5     = !v5 || r6;
  assign r4     = !v4 || r5;
  assign leave3 = (k3 != ACT_CLASSIFY) || r4;
  assign r3     = !v3 || leave3;
  assign r2     = !v2 || r3;
  assign r1     = !v1 || r2;

  assign in_ready  = r1;
  assign out_valid = ov;

  assign en.s1     = in_valid && r1;
  assign en.s2     = v1 && r2;
  assign en.s3     = v2 && r3;
  assign en.commit = v3 && leave3;
  assign en.s4     = v3 && (k3 == ACT_CLASSIFY) && r4;
  assign en.s5     = v4 && r5;
  assign en.s6     = v5 && r6;
  assign en.out    = v6 && r_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      ov <= 1'b0;
    end else begin
      v1 <= en.s1 || (v1 && !r2);
      v2 <= en.s2 || (v2 && !r3);
      v3 <= en.s3 || (v3 && !leave3);
      v4 <= en.s4 || (v4 && !r5);
      v5 <= en.s5 || (v5 && !r6);
      v6 <= en.s6 || (v6 && !r_out);
      ov <= en.out || (ov && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) k1 <= action;
    if (en.s2) k2 <= k1;
    if (en.s3) k3 <= k2;
  end

endmodule

>>> hdl/psc_plane.sv
module psc_plane (
  input  logic                               clk,
  input  logic                               rst,
  input  psc_pkg::psc_en_t                   en,
  input  logic                               action,
  input  logic [psc_pkg::SLOT_BITS-1:0]      point_slot,
  input  logic signed [psc_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [psc_pkg::COORD_BITS-1:0] point_y,
  input  logic signed [psc_pkg::COORD_BITS-1:0] elevation,
  output psc_pkg::psc_point_t                anchor,
  output logic                               complete,
  output psc_pkg::psc_normal_t               normal
);
  import psc_pkg::*;

  coord_t px [3];
  coord_t py [3];
  coord_t pz [3];
  coord_t mx [3];
  coord_t my [3];
  coord_t mz [3];
  logic [2:0] present;
  logic [2:0] present_next;
  logic slot_ok;
  logic load;

  diff_t ux, uy, uz, vx, vy, vz;
  logic dn1, dn2, dn3;
  logic signed [PROD_W-1:0] p_uyvz, p_uzvy, p_uzvx, p_uxvz, p_uxvy, p_uyvx;
  norm_t na, nb, nc;

  always_comb begin
    case (point_slot)
      2'd0:    slot_ok = 1'b1;
      2'd1:    slot_ok = present[0];
      2'd2:    slot_ok = &present[1:0];
      default: slot_ok = 1'b0;
    endcase
  end

  assign load         = en.s1 && (action == ACT_LOAD) && slot_ok;
  assign present_next = present | (3'b001 << point_slot);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (load && (point_slot == SLOT_BITS'(i))) begin
        mx[i] = point_x;
        my[i] = point_y;
        mz[i] = elevation;
      end else begin
        mx[i] = px[i];
        my[i] = py[i];
        mz[i] = pz[i];
      end
    end
  end

  assign anchor.x = px[0];
  assign anchor.y = py[0];
  assign anchor.z = pz[0];
  assign complete = &present;

  always_ff @(posedge clk) begin
    if (load) begin
      px[point_slot] <= point_x;
      py[point_slot] <= point_y;
      pz[point_slot] <= elevation;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 3'b000;
    end else if (load) begin
      present <= present_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      ux  <= DIFF_W'(mx[1]) - DIFF_W'(mx[0]);
      uy  <= DIFF_W'(my[1]) - DIFF_W'(my[0]);
      uz  <= DIFF_W'(mz[1]) - DIFF_W'(mz[0]);
      vx  <= DIFF_W'(mx[2]) - DIFF_W'(mx[0]);
      vy  <= DIFF_W'(my[2]) - DIFF_W'(my[0]);
      vz  <= DIFF_W'(mz[2]) - DIFF_W'(mz[0]);
      dn1 <= load && (present_next == 3'b111);
    end
    if (en.s2) begin
      p_uyvz <= uy * vz;
      p_uzvy <= uz * vy;
      p_uzvx <= uz * vx;
      p_uxvz <= ux * vz;
      p_uxvy <= ux * vy;
      p_uyvx <= uy * vx;
      dn2    <= dn1;
    end
    if (en.s3) begin
      na  <= NORM_W'(p_uyvz) - NORM_W'(p_uzvy);
      nb  <= NORM_W'(p_uzvx) - NORM_W'(p_uxvz);
      nc  <= NORM_W'(p_uxvy) - NORM_W'(p_uyvx);
      dn3 <= dn2;
    end
  end

  // The normal is flipped so that its vertical part is never negative.
  always_ff @(posedge clk) begin
    if (rst) begin
      normal <= '0;
    end else if (en.commit && dn3) begin
      if (nc[NORM_W-1]) begin
        normal.a <= -na;
        normal.b <= -nb;
        normal.c <= -nc;
      end else begin
        normal.a <= na;
        normal.b <= nb;
        normal.c <= nc;
      end
    end
  end

endmodule

>>> hdl/psc_sample.sv
module psc_sample (
  input  logic                                  clk,
  input  psc_pkg::psc_en_t                      en,
  input  logic [psc_pkg::COL_BITS-1:0]          column,
  input  logic [psc_pkg::ROW_BITS-1:0]          row,
  input  logic signed [psc_pkg::COORD_BITS-1:0] elevation,
  input  psc_pkg::psc_point_t                   anchor,
  input  logic                                  complete,
  input  psc_pkg::psc_normal_t                  normal,
  input  logic signed [psc_pkg::COORD_BITS-1:0] origin_x,
  input  logic signed [psc_pkg::COORD_BITS-1:0] origin_y,
  input  logic signed [psc_pkg::STEP_BITS-1:0]  step_x,
  input  logic signed [psc_pkg::STEP_BITS-1:0]  step_y,
  output logic signed [1:0]                     side,
  output logic                                  plane_valid
);
  import psc_pkg::*;

  logic [COL_BITS-1:0] col1;
  logic [ROW_BITS-1:0] row1;
  coord_t z1s, ax1, ay1, az1, ax2, ay2;
  logic pv1, pv2, pv3, pv4, pv5, pv6;
  logic signed [OFFS_W-1:0] offx2, offy2;
  diff_t dz2;
  logic signed [DELTA_W-1:0] dx3, dy3, dz3;
  logic signed [PLO_W-1:0] pal4, pbl4, pcl4;
  logic signed [PHI_W-1:0] pah4, pbh4, pch4;
  logic signed [TERM_W-1:0] ta5, tb5, tc5;
  logic signed [SUM_W-1:0] sum6;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      col1 <= column;
      row1 <= row;
      z1s  <= elevation;
      ax1  <= anchor.x;
      ay1  <= anchor.y;
      az1  <= anchor.z;
      pv1  <= complete;
    end
    if (en.s2) begin
      offx2 <= $signed({1'b0, col1}) * step_x;
      offy2 <= $signed({1'b0, row1}) * step_y;
      dz2   <= DIFF_W'(z1s) - DIFF_W'(az1);
      ax2   <= ax1;
      ay2   <= ay1;
      pv2   <= pv1;
    end
    if (en.s3) begin
      dx3 <= DELTA_W'(origin_x) + DELTA_W'(offx2) - DELTA_W'(ax2);
      dy3 <= DELTA_W'(origin_y) + DELTA_W'(offy2) - DELTA_W'(ay2);
      dz3 <= DELTA_W'(dz2);
      pv3 <= pv2;
    end
    // Each normal component is split into an unsigned low half and a signed high half.
    if (en.s4) begin
      pal4 <= $signed({1'b0, normal.a[LO_W-1:0]}) * dx3;
      pah4 <= $signed(normal.a[NORM_W-1:LO_W]) * dx3;
      pbl4 <= $signed({1'b0, normal.b[LO_W-1:0]}) * dy3;
      pbh4 <= $signed(normal.b[NORM_W-1:LO_W]) * dy3;
      pcl4 <= $signed({1'b0, normal.c[LO_W-1:0]}) * dz3;
      pch4 <= $signed(normal.c[NORM_W-1:LO_W]) * dz3;
      pv4  <= pv3;
    end
    if (en.s5) begin
      ta5 <= (TERM_W'(pah4) <<< LO_W) + TERM_W'(pal4);
      tb5 <= (TERM_W'(pbh4) <<< LO_W) + TERM_W'(pbl4);
      tc5 <= (TERM_W'(pch4) <<< LO_W) + TERM_W'(pcl4);
      pv5 <= pv4;
    end
    if (en.s6) begin
      sum6 <= SUM_W'(ta5) + SUM_W'(tb5) + SUM_W'(tc5);
      pv6  <= pv5;
    end
    if (en.out) begin
      if (!pv6) begin
        side <= SIDE_ON;
      end else if (sum6[SUM_W-1]) begin
        side <= SIDE_BELOW;
      end else if (|sum6) begin
        side <= SIDE_ABOVE;
      end else begin
        side <= SIDE_ON;
      end
      plane_valid <= pv6;
    end
  end

endmodule
